// ----- sv/ata_pkg.sv -----
package ata_pkg;

	localparam int unsigned CordicSteps = 16;
	localparam int unsigned AccW = 22;
	localparam int unsigned VecW = 44;
	localparam int unsigned SqW = 49;
	localparam int unsigned RootW = 25;

	localparam logic signed [AccW-1:0] Ang90 = 22'sd230400;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic sqrt_step;
		logic roll_start;
		logic pitch_start;
		logic cordic_step;
		logic roll_done;
		logic pitch_done;
		logic res_load;
	} ata_cmd_t;

	function automatic logic [AccW-1:0] atan_entry(input logic [3:0] i);
		logic [AccW-1:0] v;
		begin
			case (i)
				4'd0: v = 22'd115200;
				4'd1: v = 22'd68007;
				4'd2: v = 22'd35933;
				4'd3: v = 22'd18240;
				4'd4: v = 22'd9155;
				4'd5: v = 22'd4582;
				4'd6: v = 22'd2292;
				4'd7: v = 22'd1146;
				4'd8: v = 22'd573;
				4'd9: v = 22'd286;
				4'd10: v = 22'd143;
				4'd11: v = 22'd72;
				4'd12: v = 22'd36;
				4'd13: v = 22'd18;
				4'd14: v = 22'd9;
				4'd15: v = 22'd4;
				default: v = '0;
			endcase
			return v;
		end
	endfunction

endpackage

// ----- sv/accel_tilt_angles.sv -----
// accelerometer tilt: each sample beat yields roll = atan2(y, z) and
// pitch = atan2(-x, |y,z|) in tenths of a degree, truncated toward zero;
// a calibrate beat (kind 1) stores the angles as offsets and reports zero,
// a measure beat reports angles minus the offsets. one sample at a time:
// 25 square-root steps, then 16 roll and 16 pitch cordic steps, each angle
// followed by a clamp, then the result register loads and the result is
// offered; the next beat is taken the cycle after that load, while that
// result still waits; a result not yet taken holds the next one back in
// its final state and so stalls the input
module accel_tilt_angles (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // accel_x, accel_y, accel_z
	input  logic        s_tuser,  // kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata   // roll_angle[12:0], pitch_angle[24:13], zeros
);

	ata_pkg::ata_cmd_t cmd;
	logic              busy, in_fire, take;
	logic [3:0]        step;
	logic signed [12:0] roll_angle;
	logic signed [11:0] pitch_angle;

	assign s_tready = !busy;
	assign in_fire = s_tvalid && s_tready;
	// result register loads once the previous result has left
	assign take = cmd.res_load;

	ata_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire),
		.out_free(m_tready), .busy(busy), .res_valid(m_tvalid),
		.step(step), .cmd(cmd)
	);

	ata_dpath u_dpath (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .step(step),
		.kind(s_tuser), .accel_x(s_tdata[15:0]), .accel_y(s_tdata[31:16]),
		.accel_z(s_tdata[47:32]), .take_result(take),
		.roll_angle(roll_angle), .pitch_angle(pitch_angle)
	);

	assign m_tdata = {7'd0, pitch_angle, roll_angle};

endmodule

// ----- sv/ata_ctrl.sv -----
module ata_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_fire,
	input  logic              out_free,
	output logic              busy,
	output logic              res_valid,
	output logic [3:0]        step,
	output ata_pkg::ata_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE, ST_SQRT, ST_ROLL, ST_PITCH, ST_DONE
	} state_t;

	// last square-root step, and the clamp cycle after the cordic steps
	localparam logic [4:0] LastSqrt = 5'(ata_pkg::RootW - 1);
	localparam logic [4:0] LastRot = 5'(ata_pkg::CordicSteps);

	state_t     state_q;
	logic [4:0] cnt_q;

	assign step = cnt_q[3:0];
	assign busy = (state_q != ST_IDLE);

	always_comb begin
		cmd = '0;
		cmd.load = in_fire;
		cmd.sqrt_step = (state_q == ST_SQRT);
		cmd.roll_start = (state_q == ST_SQRT) && (cnt_q == LastSqrt);
		cmd.cordic_step = ((state_q == ST_ROLL) || (state_q == ST_PITCH)) && (cnt_q != LastRot);
		cmd.pitch_start = (state_q == ST_ROLL) && (cnt_q == LastRot);
		cmd.roll_done = cmd.pitch_start;
		cmd.pitch_done = (state_q == ST_PITCH) && (cnt_q == LastRot);
		cmd.res_load = (state_q == ST_DONE) && (!res_valid || out_free);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			res_valid <= 1'b0;
		end else begin
			if (cmd.res_load) res_valid <= 1'b1;
			else if (out_free) res_valid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (in_fire) state_q <= ST_SQRT;
				end
				ST_SQRT: begin
					if (cnt_q == LastSqrt) begin
						cnt_q <= '0;
						state_q <= ST_ROLL;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				ST_ROLL: begin
					if (cnt_q == LastRot) begin
						cnt_q <= '0;
						state_q <= ST_PITCH;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				ST_PITCH: begin
					if (cnt_q == LastRot) state_q <= ST_DONE;
					else cnt_q <= cnt_q + 5'd1;
				end
				ST_DONE: begin
					if (cmd.res_load) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROLL || state_q == ST_PITCH) |-> cnt_q <= LastRot)
		else $error("cordic counter overrun");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !in_fire) else $error("beat taken while busy");
	a_done_once: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pitch_done |=> state_q == ST_DONE) else $error("done lost");
`endif

endmodule

// ----- sv/ata_dpath.sv -----
module ata_dpath (
	input  logic               clk,
	input  logic               arst_n,
	input  ata_pkg::ata_cmd_t  cmd,
	input  logic [3:0]         step,
	input  logic               kind,
	input  logic signed [15:0] accel_x,
	input  logic signed [15:0] accel_y,
	input  logic signed [15:0] accel_z,
	input  logic               take_result,
	output logic signed [12:0] roll_angle,
	output logic signed [11:0] pitch_angle
);

	localparam int unsigned VW = ata_pkg::VecW;
	localparam int unsigned AW = ata_pkg::AccW;
	localparam int unsigned RW = ata_pkg::RootW;
	localparam int unsigned RemW = ata_pkg::SqW + 2;

	logic               kind_q;
	logic signed [16:0] ax_q, ay_q, az_q;
	logic [ata_pkg::SqW-1:0] rem_q;
	logic [RW-1:0]      root_q;
	logic [2*RW-1:0]    src_q;

	logic signed [VW-1:0] x_q, y_q;
	logic signed [AW-1:0] acc_q;
	logic                 spec_q; // angle fixed by an axis case
	logic signed [11:0]   spec_v_q;
	logic signed [11:0]   roll_raw_q, pitch_raw_q, roll_base_q, pitch_base_q;
	logic signed [11:0]   cur_angle;
	logic signed [AW-1:0] qv;

	// bit-serial square root of (y^2+z^2)<<16, two bits per step from the top
	logic [33:0]     ysq, zsq;
	logic [RemW-1:0] rem_sh;
	logic [RW+1:0]   tst;
	assign ysq = 34'(accel_y) * 34'(accel_y);
	assign zsq = 34'(accel_z) * 34'(accel_z);
	assign rem_sh = {rem_q, src_q[2*RW-1 -: 2]};
	assign tst = {root_q, 2'b01};

	// cordic operand setup
	function automatic void setup(input logic signed [VW-1:0] yv, input logic signed [VW-1:0] xv,
		output logic signed [VW-1:0] xo, output logic signed [VW-1:0] yo,
		output logic signed [AW-1:0] ao);
		begin
			xo = xv; yo = yv; ao = '0;
			if (xv < 0) begin
				if (yv > 0) begin xo = yv; yo = -xv; ao = ata_pkg::Ang90; end
				else begin xo = -yv; yo = xv; ao = -ata_pkg::Ang90; end
			end
			xo = xo <<< 16;
			yo = yo <<< 16;
		end
	endfunction

	logic signed [VW-1:0] xs, ys;
	logic signed [AW-1:0] as_;
	logic signed [VW-1:0] sy_in, sx_in;
	logic                 neg_lim;

	always_comb begin
		if (cmd.roll_start) begin
			sy_in = VW'(ay_q);
			sx_in = VW'(az_q);
		end else begin
			sy_in = VW'(-ax_q) <<< 8;
			sx_in = VW'($signed({1'b0, root_q}));
		end
		setup(sy_in, sx_in, xs, ys, as_);
	end
	assign neg_lim = cmd.roll_start;

	assign qv = (acc_q < 0) ? -((-acc_q) >>> 8) : (acc_q >>> 8);

	always_comb begin
		logic signed [AW-1:0] lim;
		lim = cmd.roll_done ? AW'(1800) : AW'(900);
		if (spec_q) cur_angle = spec_v_q;
		else if (qv > lim) cur_angle = 12'(lim);
		else if (qv < -lim) cur_angle = 12'(-lim);
		else cur_angle = 12'(qv);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			roll_base_q <= '0;
			pitch_base_q <= '0;
		end else if (cmd.pitch_done && kind_q) begin
			roll_base_q <= roll_raw_q;
			pitch_base_q <= cur_angle;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= kind;
			ax_q <= 17'(accel_x);
			ay_q <= 17'(accel_y);
			az_q <= 17'(accel_z);
			rem_q <= '0;
			root_q <= '0;
			src_q <= {ysq + zsq, 16'd0};
		end
		if (cmd.sqrt_step) begin
			src_q <= {src_q[2*RW-3:0], 2'b00};
			if (rem_sh >= RemW'(tst)) begin
				rem_q <= ata_pkg::SqW'(rem_sh - RemW'(tst));
				root_q <= {root_q[RW-2:0], 1'b1};
			end else begin
				rem_q <= ata_pkg::SqW'(rem_sh);
				root_q <= {root_q[RW-2:0], 1'b0};
			end
		end
		if (cmd.roll_start || cmd.pitch_start) begin
			x_q <= xs; y_q <= ys; acc_q <= as_;
			if (sy_in == 0) begin
				spec_q <= 1'b1;
				spec_v_q <= (sx_in >= 0) ? 12'sd0 : (neg_lim ? 12'sd1800 : 12'sd900);
			end else if (sx_in == 0) begin
				spec_q <= 1'b1;
				spec_v_q <= (sy_in > 0) ? 12'sd900 : -12'sd900;
			end else begin
				spec_q <= 1'b0;
				spec_v_q <= '0;
			end
		end else if (cmd.cordic_step) begin
			if (y_q > 0) begin
				x_q <= x_q + (y_q >>> step);
				y_q <= y_q - (x_q >>> step);
				acc_q <= acc_q + $signed(ata_pkg::atan_entry(step));
			end else begin
				x_q <= x_q - (y_q >>> step);
				y_q <= y_q + (x_q >>> step);
				acc_q <= acc_q - $signed(ata_pkg::atan_entry(step));
			end
		end
		if (cmd.roll_done) roll_raw_q <= cur_angle;
		if (cmd.pitch_done) pitch_raw_q <= cur_angle;
		if (take_result) begin
			if (kind_q) begin
				roll_angle <= '0;
				pitch_angle <= '0;
			end else begin
				roll_angle <= 13'(roll_raw_q) - 13'(roll_base_q);
				pitch_angle <= pitch_raw_q - pitch_base_q;
			end
		end
	end

endmodule

// ----- test/tb_accel_tilt_angles.sv -----
module tb_accel_tilt_angles;

	// ---------------------------------------------------------------------------------------
	// clock, reset and block ports
	// ---------------------------------------------------------------------------------------
	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;   // accel_x, accel_y, accel_z
	logic        s_tuser;   // kind
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;   // roll_angle[12:0], pitch_angle[24:13], zeros

	// kinds of sample beat
	localparam logic KIND_MEASURE   = 1'b0;
	localparam logic KIND_CALIBRATE = 1'b1;

	// the angle accumulator counts 1/256 of a tenth of a degree
	localparam longint QUARTER_TURN = 230400;

	typedef struct packed {
		logic signed [12:0] roll;
		logic signed [11:0] pitch;
	} tilt_t;

	tilt_t     tilt_q[$];       // angles still owed by the block
	int        roll_cal;        // offsets held by the predictor
	int        pitch_cal;
	bit        failed;
	bit        hold_sink;       // forces a long receiver stall
	int        holds_begun;     // long stalls started so far
	int        holds_served;    // long stalls finished so far
	longint    arctan_lut[16];

	accel_tilt_angles u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// ---------------------------------------------------------------------------------------
	// tilt predictor
	// ---------------------------------------------------------------------------------------

	// floor of a square root, bit by bit
	function automatic longint int_sqrt(input longint v);
		longint root;
		longint bitpos;
		begin
			root = 0;
			bitpos = 64'sd1 <<< 62;
			while (bitpos > v)
				bitpos = bitpos >>> 2;
			while (bitpos != 0) begin
				if (v >= root + bitpos) begin
					v = v - (root + bitpos);
					root = (root >>> 1) + bitpos;
				end else begin
					root = root >>> 1;
				end
				bitpos = bitpos >>> 2;
			end
			return root;
		end
	endfunction

	// atan2(num, den) in tenths of a degree, truncated, clamped to +-lim
	function automatic int vector_angle(input longint num, input longint den, input int lim);
		longint vx;
		longint vy;
		longint acc;
		longint step_x;
		longint step_y;
		longint q;
		begin
			acc = 0;
			// on the positive axis, on the negative axis, or straight up / down
			if (num == 0)
				return (den >= 0) ? 0 : ((lim < 1800) ? lim : 1800);
			if (den == 0)
				return (num > 0) ? 900 : -900;
			// fold the left half plane onto the right one
			if (den < 0) begin
				if (num > 0) begin
					vx = num;
					vy = -den;
					acc = QUARTER_TURN;
				end else begin
					vx = -num;
					vy = den;
					acc = -QUARTER_TURN;
				end
			end else begin
				vx = den;
				vy = num;
			end
			vx = vx * 65536;
			vy = vy * 65536;
			for (int i = 0; i < 16; i++) begin
				// arithmetic shifts floor toward minus infinity
				step_x = vy >>> i;
				step_y = vx >>> i;
				if (vy > 0) begin
					vx = vx + step_x;
					vy = vy - step_y;
					acc = acc + arctan_lut[i];
				end else begin
					vx = vx - step_x;
					vy = vy + step_y;
					acc = acc - arctan_lut[i];
				end
			end
			q = acc / 256;
			if (q > lim)
				q = lim;
			if (q < -lim)
				q = -lim;
			return int'(q);
		end
	endfunction

	// advance the offsets for one beat and return the angles it must report
	function automatic tilt_t predict_tilt(input logic kind, input logic signed [15:0] ax,
	                                       input logic signed [15:0] ay,
	                                       input logic signed [15:0] az);
		longint yz_mag;
		int     roll;
		int     pitch;
		tilt_t  t;
		begin
			yz_mag = int_sqrt((longint'(ay) * ay + longint'(az) * az) * 65536);
			roll = vector_angle(longint'(ay), longint'(az), 1800);
			pitch = vector_angle(-longint'(ax) * 256, yz_mag, 900);
			if (kind == KIND_CALIBRATE) begin
				roll_cal = roll;
				pitch_cal = pitch;
				t = '0;
			end else begin
				t.roll = 13'(roll - roll_cal);
				t.pitch = 12'(pitch - pitch_cal);
			end
			return t;
		end
	endfunction

	// ---------------------------------------------------------------------------------------
	// sender side
	// ---------------------------------------------------------------------------------------

	// mostly no gap at all, often a short one, now and then a long one
	function automatic int gap_len();
		int r;
		begin
			r = $urandom_range(0, 99);
			if (r < 55)
				return 0;
			if (r < 93)
				return $urandom_range(1, 3);
			return $urandom_range(10, 80);
		end
	endfunction

	// valid stays high after an accepted beat when the next one follows at once
	task automatic send_sample(input logic kind, input int ax, input int ay, input int az,
	                           input bit with_gaps);
		int gap;
		begin
			gap = with_gaps ? gap_len() : 0;
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap)
					@(posedge clk);
			end
			s_tvalid <= 1'b1;
			s_tuser <= kind;
			s_tdata <= {16'(az), 16'(ay), 16'(ax)};
			@(posedge clk);
			while (!s_tready)
				@(posedge clk);
			tilt_q.push_back(predict_tilt(kind, 16'(ax), 16'(ay), 16'(az)));
		end
	endtask

	task automatic wait_drained();
		int guard;
		begin
			s_tvalid <= 1'b0;
			@(posedge clk);
			guard = 0;
			while (tilt_q.size() != 0 && guard < 200000) begin
				@(posedge clk);
				guard++;
			end
		end
	endtask

	function automatic int rand_axis();
		int r;
		begin
			r = $urandom_range(0, 9);
			if (r == 0)
				return -32768;
			if (r == 1)
				return 32767;
			if (r == 2)
				return 0;
			if (r < 5)
				return int'($urandom_range(0, 600)) - 300;
			return int'($signed(16'($urandom)));
		end
	endfunction

	// ---------------------------------------------------------------------------------------
	// receiver side and result check
	// ---------------------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_sink) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) < 70);
		end
	end

	// occasional long receiver stretch
	initial begin
		hold_sink = 1'b0;
		holds_begun = 0;
		holds_served = 0;
		@(posedge arst_n);
		forever begin
			repeat ($urandom_range(200, 2000))
				@(posedge clk);
			hold_sink <= 1'b1;
			holds_begun <= holds_begun + 1;
			repeat ($urandom_range(300, 600))
				@(posedge clk);
			hold_sink <= 1'b0;
			holds_served <= holds_served + 1;
		end
	end

	always @(posedge clk) begin
		tilt_t want;
		tilt_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.roll = m_tdata[12:0];
			got.pitch = m_tdata[24:13];
			if (tilt_q.size() == 0) begin
				$display("%0t: unexpected result beat, actual roll %0d pitch %0d",
				         $time, got.roll, got.pitch);
				failed = 1'b1;
			end else begin
				want = tilt_q.pop_front();
				if (got.roll !== want.roll) begin
					$display("%0t: roll mismatch, expected %0d actual %0d",
					         $time, want.roll, got.roll);
					failed = 1'b1;
				end
				if (got.pitch !== want.pitch) begin
					$display("%0t: pitch mismatch, expected %0d actual %0d",
					         $time, want.pitch, got.pitch);
					failed = 1'b1;
				end
				if (m_tdata[31:25] !== 7'd0) begin
					$display("%0t: pad bits, expected 0 actual %0h", $time, m_tdata[31:25]);
					failed = 1'b1;
				end
			end
		end
	end

	// ---------------------------------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------------------------------

	// axes, extremes and the atan2 corner cases, no gaps
	task automatic test_corners();
		begin
			send_sample(KIND_MEASURE, 0, 0, 0, 1'b0);              // both operands zero
			send_sample(KIND_MEASURE, 0, 0, 16000, 1'b0);          // flat
			send_sample(KIND_MEASURE, 0, 0, -16000, 1'b0);         // upside down, 180
			send_sample(KIND_MEASURE, 0, 16000, 0, 1'b0);          // roll +90
			send_sample(KIND_MEASURE, 0, -16000, 0, 1'b0);         // roll -90
			send_sample(KIND_MEASURE, 16000, 0, 0, 1'b0);          // pitch -90
			send_sample(KIND_MEASURE, -16000, 0, 0, 1'b0);         // pitch +90
			send_sample(KIND_MEASURE, -32768, -32768, -32768, 1'b0);
			send_sample(KIND_MEASURE, 32767, 32767, 32767, 1'b0);
			send_sample(KIND_MEASURE, 32767, -32768, 32767, 1'b0);
			send_sample(KIND_MEASURE, -32768, 32767, -32768, 1'b0);
			send_sample(KIND_MEASURE, 0, 1, -32768, 1'b0);         // roll clamp near +180
			send_sample(KIND_MEASURE, 0, -1, -32768, 1'b0);        // roll clamp near -180
			send_sample(KIND_MEASURE, 1, 0, -1, 1'b0);
			send_sample(KIND_MEASURE, -1, 1, 1, 1'b0);
		end
	endtask

	// calibrate, then measure against the new offsets
	task automatic test_offsets();
		begin
			send_sample(KIND_CALIBRATE, 1000, -2000, 3000, 1'b0);
			send_sample(KIND_MEASURE, 0, 0, 16000, 1'b0);
			send_sample(KIND_MEASURE, 0, 0, -16000, 1'b0);
			send_sample(KIND_CALIBRATE, -32768, 1, -32768, 1'b0);
			send_sample(KIND_MEASURE, 32767, -1, -32768, 1'b0);
			send_sample(KIND_MEASURE, -32768, 0, 0, 1'b0);
			send_sample(KIND_CALIBRATE, 0, 0, 0, 1'b0);
			send_sample(KIND_MEASURE, 123, 456, 789, 1'b0);
		end
	endtask

	// random samples with random gaps, calibrations now and then
	task automatic test_random(input int n);
		logic kind;
		begin
			for (int i = 0; i < n; i++) begin
				kind = ($urandom_range(0, 9) == 0) ? KIND_CALIBRATE : KIND_MEASURE;
				send_sample(kind, rand_axis(), rand_axis(), rand_axis(), 1'b1);
			end
		end
	endtask

	// keep offering beats until a long receiver stall begun after this point has ended
	task automatic test_backpressure();
		int guard;
		int begun;
		begin
			guard = 0;
			begun = holds_begun;
			while (holds_served <= begun && guard < 400) begin
				send_sample(KIND_MEASURE, rand_axis(), rand_axis(), rand_axis(), 1'b0);
				guard++;
			end
		end
	endtask

	// ---------------------------------------------------------------------------------------
	// run
	// ---------------------------------------------------------------------------------------
	initial begin
		arctan_lut = '{115200, 68007, 35933, 18240, 9155, 4582, 2292, 1146,
		               573, 286, 143, 72, 36, 18, 9, 4};
		failed = 1'b0;
		roll_cal = 0;
		pitch_cal = 0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tuser = KIND_MEASURE;
		s_tdata = '0;
		repeat (8)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_corners();
		test_offsets();
		// sender pauses until every result is back
		wait_drained();
		test_random(400);
		test_backpressure();
		test_random(400);

		wait_drained();
		repeat (100)
			@(posedge clk);
		if (!failed && tilt_q.size() == 0) begin
			$display("tb_accel_tilt_angles: PASS");
		end else begin
			$display("tb_accel_tilt_angles: FAIL");
		end
		$finish;
	end

	initial begin
		#40000000;
		$display("tb_accel_tilt_angles: FAIL");
		$finish;
	end

endmodule

// ----- filelist.f -----
sv/ata_pkg.sv
sv/ata_ctrl.sv
sv/ata_dpath.sv
sv/accel_tilt_angles.sv
test/tb_accel_tilt_angles.sv
